[sv/adbar_pkg.sv]
// adbar_pkg: shared types, command codes and helpers for the desktop-bus
// address resolution sequencer. No dependencies.
`default_nettype none

package adbar_pkg;

  // input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_REPLY = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // result kinds
  localparam logic [2:0] K_RESET  = 3'd0;
  localparam logic [2:0] K_TALK   = 3'd1;
  localparam logic [2:0] K_LISTEN = 3'd2;
  localparam logic [2:0] K_DONE   = 3'd3;
  localparam logic [2:0] K_NOFREE = 3'd4;
  localparam logic [2:0] K_ENTRY  = 3'd5;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]  cmd_kind;
    logic [3:0]  cmd_addr;
    logic [3:0]  new_addr;
    logic [15:0] poll_list;
    logic        entry_present;
    logic [3:0]  entry_default_addr;
    logic [7:0]  entry_handler;
    logic        last;
  } result_t;

  // device table record
  typedef struct packed {
    logic [3:0] default_addr;
    logic [7:0] handler;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic result_t mk_cmd(input logic [2:0] kind, input logic [3:0] addr,
                                     input logic [3:0] naddr, input logic [15:0] poll);
    result_t r;
    r = '0;
    r.cmd_kind  = kind;
    r.cmd_addr  = addr;
    r.new_addr  = naddr;
    r.poll_list = poll;
    return r;
  endfunction

  // highest set bit, 0 when none above bit 0
  function automatic logic [3:0] top_bit(input logic [15:0] m);
    logic [3:0] r;
    r = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (m[b]) r = 4'(b);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/adbar_ifs.sv]
// adbar_ifs: valid/ready channel interfaces for request items and result items.
// Depends on nothing.
`default_nettype none

interface adbar_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       responded;
  logic [7:0] reply_handler;
  logic [3:0] entry_index;

  modport source (output valid, mode, responded, reply_handler, entry_index, input ready);
  modport sink   (input valid, mode, responded, reply_handler, entry_index, output ready);
endinterface

interface adbar_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd_kind;
  logic [3:0]  cmd_addr;
  logic [3:0]  new_addr;
  logic [15:0] poll_list;
  logic        entry_present;
  logic [3:0]  entry_default_addr;
  logic [7:0]  entry_handler;
  logic        last;

  modport source (output valid, cmd_kind, cmd_addr, new_addr, poll_list, entry_present,
                  entry_default_addr, entry_handler, last, input ready);
  modport sink   (input valid, cmd_kind, cmd_addr, new_addr, poll_list, entry_present,
                  entry_default_addr, entry_handler, last, output ready);
endinterface

`default_nettype wire

[sv/adbar_ram.sv]
// adbar_ram: generic RAM, one write port, two registered read ports.
// Read-first on an address written in the same cycle. No dependencies.
`default_nettype none

module adbar_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

[sv/adbar_result_queue.sv]
// adbar_result_queue: small result FIFO taking up to two results per cycle
// and driving the result channel. Depends on adbar_pkg and adbar_ifs.
`default_nettype none

module adbar_result_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               push_n,
  input  adbar_pkg::result_t       push0,
  input  adbar_pkg::result_t       push1,
  output logic [adbar_pkg::QCW-1:0] room,
  adbar_out_if.source              rsp
);
  import adbar_pkg::*;

  result_t          q [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QCW-1:0]   count;
  logic             pop;
  result_t          head;

  assign pop  = rsp.valid && rsp.ready;
  assign room = QCW'(QDEPTH) - count;
  assign head = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QAW'(push_n);
      rptr  <= rptr + QAW'(pop);
      count <= count + QCW'(push_n) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q[wptr] <= push0;
    if (push_n == 2'd2) q[wptr + QAW'(1)] <= push1;
  end

  assign rsp.valid              = (count != '0);
  assign rsp.cmd_kind           = head.cmd_kind;
  assign rsp.cmd_addr           = head.cmd_addr;
  assign rsp.new_addr           = head.new_addr;
  assign rsp.poll_list          = head.poll_list;
  assign rsp.entry_present      = head.entry_present;
  assign rsp.entry_default_addr = head.entry_default_addr;
  assign rsp.entry_handler      = head.entry_handler;
  assign rsp.last               = head.last;

endmodule

`default_nettype wire

[sv/adb_address_resolution_unit.sv]
// adb_address_resolution_unit: desktop-bus address resolution sequencer.
// Accepted items' results are registered in s1, then in the result queue.
// Throughput: one item per cycle if the queue has room; results leave at one
// per cycle; two-result items (start, move, move back) are queue-paced.
// Reset: synchronous, idle phase, empty table, empty result queue.
// Depends on adbar_pkg, adbar_ifs, adbar_ram, adbar_result_queue.
`default_nettype none

module adb_address_resolution_unit #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  adbar_in_if.sink     req,
  adbar_out_if.source  rsp
);
  import adbar_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam logic [SLOTS-1:0] ONE       = {{(SLOTS-1){1'b0}}, 1'b1};
  localparam logic [SLOTS-1:0] FREE_INIT = {{(SLOTS-1){1'b1}}, 1'b0};

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SCAN    = 3'd1;
  localparam logic [2:0] PH_MOVE    = 3'd2;
  localparam logic [2:0] PH_REPROBE = 3'd3;
  localparam logic [2:0] PH_BACK    = 3'd4;

  logic [2:0]       phase, phase_next;
  logic [3:0]       scan_address, scan_next;
  logic [SLOTS-1:0] unresolved_mask, unres_next;
  logic [SLOTS-1:0] free_mask, free_next;
  logic [SLOTS-1:0] present, present_next;
  logic [3:0]       device_slot, device_next;
  logic [3:0]       spare_slot, spare_next;
  rec_t             moved_rec, moved_next;

  logic             req_acc;
  logic             do_resolve;
  result_t          r0, r1;
  logic [1:0]       n_res;
  logic             is_entry;

  // table write port
  logic             we;
  logic [AW-1:0]    waddr;
  rec_t             wdata;

  logic [AW-1:0]    dn_i, fn_i, sc_i, idx_i;
  logic [REC_W-1:0] ra_raw, rb_raw;
  rec_t             ra_rec, dev_rec;
  logic             fwd_valid;
  rec_t             fwd_data;

  // result register stage
  logic             s1_valid;
  logic [1:0]       s1_cnt;
  logic             s1_entry;
  logic [AW-1:0]    s1_idx;
  result_t          s1_r0, s1_r1;
  logic             s1_move;
  logic [QCW-1:0]   room;
  logic [1:0]       push_n;
  result_t          push0;
  logic [AW-1:0]    ra_addr;

  assign dn_i  = device_slot[AW-1:0];
  assign fn_i  = spare_slot[AW-1:0];
  assign sc_i  = scan_address[AW-1:0];
  assign idx_i = req.entry_index[AW-1:0];

  assign s1_move   = s1_valid && (room >= QCW'(s1_cnt));
  assign req.ready = !s1_valid || s1_move;
  assign req_acc   = req.valid && req.ready;

  // record currently held at device_slot (RAM read plus same-cycle bypass)
  assign ra_rec  = rec_t'(ra_raw);
  assign dev_rec = fwd_valid ? fwd_data : rec_t'(rb_raw);
  assign ra_addr = req_acc ? idx_i : s1_idx;

  always_comb begin
    phase_next   = phase;
    scan_next    = scan_address;
    unres_next   = unresolved_mask;
    free_next    = free_mask;
    present_next = present;
    device_next  = device_slot;
    spare_next   = spare_slot;
    moved_next   = moved_rec;
    do_resolve   = 1'b0;
    r0           = '0;
    r1           = '0;
    n_res        = 2'd0;
    is_entry     = 1'b0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;

    if (req_acc) begin
      case (req.mode)
        MODE_START: begin
          phase_next   = PH_SCAN;
          scan_next    = 4'd1;
          unres_next   = '0;
          free_next    = FREE_INIT;
          present_next = '0;
          device_next  = 4'd0;
          spare_next   = 4'd0;
          r0           = mk_cmd(K_RESET, 4'd0, 4'd0, 16'd0);
          r1           = mk_cmd(K_TALK, 4'd1, 4'd0, 16'd0);
          n_res        = 2'd2;
        end
        MODE_READ: begin
          r0 = mk_cmd(K_ENTRY, req.entry_index, 4'd0, 16'd0);
          r0.entry_present = (int'(req.entry_index) < SLOTS) && present[idx_i];
          n_res    = 2'd1;
          is_entry = 1'b1;
        end
        MODE_REPLY: begin
          case (phase)
            PH_SCAN: begin
              if (req.responded) begin
                if (!present[sc_i]) begin
                  we    = 1'b1;
                  waddr = sc_i;
                  wdata = '{default_addr: scan_address, handler: req.reply_handler};
                end
                present_next[sc_i] = 1'b1;
                unres_next = unresolved_mask | (ONE << sc_i);
                free_next  = free_mask & ~(ONE << sc_i);
              end
              scan_next = scan_address + 4'd1;
              if (scan_next != 4'd0 && int'(scan_next) < SLOTS) begin
                r0    = mk_cmd(K_TALK, scan_next, 4'd0, 16'd0);
                n_res = 2'd1;
              end else begin
                do_resolve = 1'b1;
              end
            end
            PH_MOVE: begin
              // record follows the device to the spare address
              we    = 1'b1;
              waddr = fn_i;
              if (present[dn_i]) wdata = dev_rec;
              else wdata = '{default_addr: spare_slot, handler: req.reply_handler};
              moved_next = wdata;
              if (req.responded) begin
                present_next[dn_i] = 1'b0;
                present_next[fn_i] = 1'b1;
                phase_next = PH_REPROBE;
                r0    = mk_cmd(K_TALK, device_slot, 4'd0, 16'd0);
                n_res = 2'd1;
              end else begin
                present_next[fn_i] = 1'b0;
                unres_next = unresolved_mask & ~(ONE << dn_i);
                do_resolve = 1'b1;
              end
            end
            PH_REPROBE: begin
              if (req.responded && !present[dn_i]) begin
                we    = 1'b1;
                waddr = dn_i;
                wdata = '{default_addr: device_slot, handler: req.reply_handler};
                present_next[dn_i] = 1'b1;
              end
              if (req.responded) begin
                // second device found: first one stays moved aside
                free_next  = free_mask & ~(ONE << fn_i);
                do_resolve = 1'b1;
              end else begin
                phase_next = PH_BACK;
                r0    = mk_cmd(K_LISTEN, spare_slot, device_slot, 16'd0);
                r1    = mk_cmd(K_TALK, device_slot, 4'd0, 16'd0);
                n_res = 2'd2;
              end
            end
            PH_BACK: begin
              we    = 1'b1;
              waddr = dn_i;
              if (present[fn_i]) wdata = moved_rec;
              else wdata = '{default_addr: device_slot, handler: req.reply_handler};
              present_next[dn_i] = present[fn_i] || req.responded;
              present_next[fn_i] = 1'b0;
              unres_next = unresolved_mask & ~(ONE << dn_i);
              do_resolve = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (do_resolve) begin
      if (unres_next == '0) begin
        phase_next = PH_IDLE;
        r0    = mk_cmd(K_DONE, 4'd0, 4'd0, 16'(free_next ^ FREE_INIT));
        n_res = 2'd1;
      end else if (free_next == '0) begin
        phase_next = PH_IDLE;
        r0    = mk_cmd(K_NOFREE, 4'd0, 4'd0, 16'd0);
        n_res = 2'd1;
      end else begin
        spare_next  = top_bit(16'(free_next));
        device_next = top_bit(16'(unres_next));
        phase_next  = PH_MOVE;
        r0    = mk_cmd(K_LISTEN, device_next, spare_next, 16'd0);
        r1    = mk_cmd(K_TALK, spare_next, 4'd0, 16'd0);
        n_res = 2'd2;
      end
    end

    if (n_res == 2'd1) r0.last = 1'b1;
    else if (n_res == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      scan_address    <= 4'd0;
      unresolved_mask <= '0;
      free_mask       <= FREE_INIT;
      present         <= '0;
      device_slot     <= 4'd0;
      spare_slot      <= 4'd0;
      fwd_valid       <= 1'b0;
      s1_valid        <= 1'b0;
    end else begin
      phase           <= phase_next;
      scan_address    <= scan_next;
      unresolved_mask <= unres_next;
      free_mask       <= free_next;
      present         <= present_next;
      device_slot     <= device_next;
      spare_slot      <= spare_next;
      fwd_valid       <= we && (waddr == device_next[AW-1:0]);
      if (req_acc) s1_valid <= (n_res != 2'd0);
      else if (s1_move) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    moved_rec <= moved_next;
    fwd_data  <= wdata;
    if (req_acc) begin
      s1_cnt   <= n_res;
      s1_entry <= is_entry;
      s1_idx   <= idx_i;
      s1_r0    <= r0;
      s1_r1    <= r1;
    end
  end

  // table data; present bits live in flops above
  adbar_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_raw),
    .rb_addr (device_next[AW-1:0]),
    .rb_data (rb_raw)
  );

  always_comb begin
    push0 = s1_r0;
    if (s1_entry && s1_r0.entry_present) begin
      push0.entry_default_addr = ra_rec.default_addr;
      push0.entry_handler      = ra_rec.handler;
    end
  end

  assign push_n = s1_move ? s1_cnt : 2'd0;

  adbar_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push0  (push0),
    .push1  (s1_r1),
    .room   (room),
    .rsp    (rsp)
  );

  a_start_restarts_scan: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.mode == MODE_START |=>
      phase == PH_SCAN && scan_address == 4'd1 && present == '0)
    else $error("start item did not restart the scan");

  a_unresolved_not_free: assert property (@(posedge clk) disable iff (rst)
    (unresolved_mask & free_mask) == '0)
    else $error("address both unresolved and free");

  a_move_slots_consistent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MOVE || phase == PH_REPROBE || phase == PH_BACK) |->
      unresolved_mask[dn_i] && free_mask[fn_i])
    else $error("device or spare slot lost during a move");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> room >= QCW'(push_n))
    else $error("result queue overflow");

endmodule

`default_nettype wire
